### rtl/core/low_battery_monitor_unit_macros.svh
// Assertion macros for the low battery monitor unit.
// No dependencies; included by the top level.
`ifndef LOW_BATTERY_MONITOR_UNIT_MACROS_SVH
`define LOW_BATTERY_MONITOR_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbm assertion failed");

// next-cycle implication, disabled in reset
`define LBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbm assertion failed");

`endif

### rtl/core/lbm_pkg.sv
// Shared types, constants and the charger state decode for the low battery monitor.
// No dependencies.
package lbm_pkg;

  localparam logic [1:0] ST_INIT      = 2'd0;
  localparam logic [1:0] ST_CARE      = 2'd1;
  localparam logic [1:0] ST_DONT_CARE = 2'd2;

  localparam logic [2:0] REG_START_DELAY = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [2:0] REG_AWAKE_INT   = 3'd2;
  localparam logic [2:0] REG_SLEEP_INT   = 3'd3;
  localparam logic [2:0] REG_CUTOFF      = 3'd4;
  localparam logic [2:0] REG_WARNING     = 3'd5;
  localparam logic [2:0] REG_WARN_HYST   = 3'd6;
  localparam logic [2:0] REG_ALERT_CORR  = 3'd7;

  localparam logic [2:0] CODE_LAST_CARE = 3'd3;
  localparam logic [2:0] CODE_LAST_DONT = 3'd6;

  typedef struct packed {
    logic [15:0] start_delay_sec;
    logic [15:0] debounce_sec;
    logic [15:0] awake_interval_sec;
    logic [15:0] sleep_interval_sec;
    logic [6:0]  cutoff_pct;
    logic [6:0]  warning_pct;
    logic [6:0]  warning_hyst_pct;
    logic [6:0]  alert_threshold_pct;
  } cfg_t;

  typedef struct packed {
    logic [31:0] uptime_sec;
    logic        sleep_disabled;
    logic [9:0]  charge_tenths;
    logic        charge_error;
    logic        bat_event_valid;
    logic [2:0]  bat_state_code;
    logic        gauge_alert;
    logic        wake_event;
  } item_t;

  typedef struct packed {
    logic        started;
    logic        pending_valid;
    logic [31:0] pending_time;
    logic [1:0]  pending_status;
    logic [1:0]  charge_status;
    logic [31:0] last_eval_time;
    logic        past_warning;
    logic        alert_seen;
    logic        shutdown_sent;
  } state_t;

  typedef struct packed {
    logic       arm_alert;
    logic [6:0] alert_threshold_pct;
    logic       shutdown_request;
    logic       warn_pulse;
    logic       recover_pulse;
    logic [1:0] status_now;
    logic       warning_active;
  } result_t;

  function automatic logic [1:0] decode_state(input logic [2:0] code);
    logic [1:0] st;
    if (code <= CODE_LAST_CARE) begin
      st = ST_CARE;
    end else if (code <= CODE_LAST_DONT) begin
      st = ST_DONT_CARE;
    end else begin
      st = ST_INIT;
    end
    return st;
  endfunction

endpackage

### rtl/core/lbm_cfg_regs.sv
// Configuration register file with the derived gauge alert threshold.
// Depends on lbm_pkg.
module lbm_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  output lbm_pkg::cfg_t  cfg
);

  logic [15:0] start_delay_r, debounce_r, awake_int_r, sleep_int_r;
  logic [6:0]  cutoff_r, warning_r, hyst_r, corr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r <= 16'd20;
      debounce_r    <= 16'd20;
      awake_int_r   <= 16'd60;
      sleep_int_r   <= 16'd60;
      cutoff_r      <= 7'd2;
      warning_r     <= 7'd8;
      hyst_r        <= 7'd5;
      corr_r        <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        lbm_pkg::REG_START_DELAY: start_delay_r <= cfg_wdata;
        lbm_pkg::REG_DEBOUNCE:    debounce_r    <= cfg_wdata;
        lbm_pkg::REG_AWAKE_INT:   awake_int_r   <= cfg_wdata;
        lbm_pkg::REG_SLEEP_INT:   sleep_int_r   <= cfg_wdata;
        lbm_pkg::REG_CUTOFF:      cutoff_r      <= cfg_wdata[6:0];
        lbm_pkg::REG_WARNING:     warning_r     <= cfg_wdata[6:0];
        lbm_pkg::REG_WARN_HYST:   hyst_r        <= cfg_wdata[6:0];
        lbm_pkg::REG_ALERT_CORR:  corr_r        <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.start_delay_sec     = start_delay_r;
    cfg.debounce_sec        = debounce_r;
    cfg.awake_interval_sec  = awake_int_r;
    cfg.sleep_interval_sec  = sleep_int_r;
    cfg.cutoff_pct          = cutoff_r;
    cfg.warning_pct         = warning_r;
    cfg.warning_hyst_pct    = hyst_r;
    cfg.alert_threshold_pct = (cutoff_r > corr_r) ? (cutoff_r - corr_r) : 7'd0;
  end

endmodule

### rtl/core/lbm_eval.sv
// One evaluation tick: next supervisor state and the result from the current item.
// Depends on lbm_pkg.
module lbm_eval (
  input  lbm_pkg::cfg_t    cfg,
  input  lbm_pkg::item_t   item,
  input  lbm_pkg::state_t  st,
  output lbm_pkg::state_t  st_nxt,
  output lbm_pkg::result_t res
);

  logic [31:0] now;
  logic [31:0] lt_wake, lt_adopt;
  logic        start_now, started1, pend_load, pv1, adopt, alert1, do_eval;
  logic [31:0] pt1;
  logic [1:0]  ps1, cs1;
  logic [15:0] interval;
  logic [11:0] charge_x, cutoff_x10, warn_x10, clear_x10;
  logic        shut, warn, recov, past_nxt, sent_nxt;

  always_comb begin
    now        = item.uptime_sec;
    lt_wake    = item.wake_event ? 32'd0 : st.last_eval_time;

    start_now  = !st.started && (now >= {16'd0, cfg.start_delay_sec});
    started1   = st.started | start_now;
    pend_load  = (start_now && (st.charge_status == lbm_pkg::ST_INIT)) ||
                 (started1 && item.bat_event_valid);
    pv1        = st.pending_valid | pend_load;
    pt1        = pend_load ? now : st.pending_time;
    ps1        = pend_load ? lbm_pkg::decode_state(item.bat_state_code) : st.pending_status;
    alert1     = st.alert_seen | (started1 & item.gauge_alert);

    adopt      = pv1 && ((now - pt1) >= {16'd0, cfg.debounce_sec});
    cs1        = adopt ? ps1 : st.charge_status;
    lt_adopt   = adopt ? now : lt_wake;

    interval   = item.sleep_disabled ? cfg.awake_interval_sec : cfg.sleep_interval_sec;
    do_eval    = started1 && ((now - lt_adopt) >= {16'd0, interval});

    charge_x   = {2'd0, item.charge_tenths};
    cutoff_x10 = 12'({5'd0, cfg.cutoff_pct} * 12'd10);
    warn_x10   = 12'({5'd0, cfg.warning_pct} * 12'd10);
    clear_x10  = 12'(({5'd0, cfg.warning_pct} + {5'd0, cfg.warning_hyst_pct}) * 12'd10);

    shut     = 1'b0;
    warn     = 1'b0;
    recov    = 1'b0;
    past_nxt = st.past_warning;
    sent_nxt = st.shutdown_sent;
    if (do_eval && !item.charge_error) begin
      if (cs1 == lbm_pkg::ST_CARE) begin
        if (alert1 || (charge_x <= cutoff_x10)) begin
          shut     = !st.shutdown_sent;
          sent_nxt = 1'b1;
        end else if (!st.past_warning && (charge_x <= warn_x10)) begin
          past_nxt = 1'b1;
          warn     = 1'b1;
        end
      end else if (cs1 == lbm_pkg::ST_DONT_CARE) begin
        if (alert1) begin
          shut     = !st.shutdown_sent;
          sent_nxt = 1'b1;
        end else if (st.past_warning && (charge_x >= clear_x10)) begin
          past_nxt = 1'b0;
          recov    = 1'b1;
        end
      end
    end

    st_nxt.started        = started1;
    st_nxt.pending_valid  = pv1 & !adopt;
    st_nxt.pending_time   = pt1;
    st_nxt.pending_status = ps1;
    st_nxt.charge_status  = cs1;
    st_nxt.last_eval_time = do_eval ? now : lt_adopt;
    st_nxt.past_warning   = past_nxt;
    st_nxt.alert_seen     = alert1;
    st_nxt.shutdown_sent  = sent_nxt;

    res.arm_alert           = start_now;
    res.alert_threshold_pct = cfg.alert_threshold_pct;
    res.shutdown_request    = shut;
    res.warn_pulse          = warn;
    res.recover_pulse       = recov;
    res.status_now          = cs1;
    res.warning_active      = past_nxt;
  end

endmodule

### rtl/core/low_battery_monitor_unit.sv
// Top level of the low battery monitor: input register, evaluation, result register.
// Depends on lbm_pkg, lbm_cfg_regs, lbm_eval and low_battery_monitor_unit_macros.svh.
//
//   channel  handshake          payload
//   in       in_valid/in_ready  in_uptime_sec .. in_wake_event
//   out      out_valid/out_ready out_arm_alert .. out_warning_active
//   cfg      cfg_we             cfg_index, cfg_wdata
//
// One request per cycle sustained while the output is not stalled; an accepted request is
// held in the input register, then its result in the result register. The evaluation
// between input and result register sets the cycle; state updates when an item moves into the result register.
// rst_n is synchronous; reset clears control and supervisor state and loads
// register defaults. A stalled output holds the input register, then in_ready drops.
`include "low_battery_monitor_unit_macros.svh"

module low_battery_monitor_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_uptime_sec,
  input  logic        in_sleep_disabled,
  input  logic [9:0]  in_charge_tenths,
  input  logic        in_charge_error,
  input  logic        in_bat_event_valid,
  input  logic [2:0]  in_bat_state_code,
  input  logic        in_gauge_alert,
  input  logic        in_wake_event,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_arm_alert,
  output logic [6:0]  out_alert_threshold_pct,
  output logic        out_shutdown_request,
  output logic        out_warn_pulse,
  output logic        out_recover_pulse,
  output logic [1:0]  out_status_now,
  output logic        out_warning_active,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  lbm_pkg::cfg_t    cfg;
  lbm_pkg::item_t   item_r;
  lbm_pkg::state_t  state_r, state_nxt;
  lbm_pkg::result_t res_nxt, res_r;
  logic             item_valid_r, out_valid_r, advance;

  lbm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lbm_eval u_eval (
    .cfg    (cfg),
    .item   (item_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.uptime_sec      <= in_uptime_sec;
      item_r.sleep_disabled  <= in_sleep_disabled;
      item_r.charge_tenths   <= in_charge_tenths;
      item_r.charge_error    <= in_charge_error;
      item_r.bat_event_valid <= in_bat_event_valid;
      item_r.bat_state_code  <= in_bat_state_code;
      item_r.gauge_alert     <= in_gauge_alert;
      item_r.wake_event      <= in_wake_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      out_valid_r <= advance || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_arm_alert           = res_r.arm_alert;
  assign out_alert_threshold_pct = res_r.alert_threshold_pct;
  assign out_shutdown_request    = res_r.shutdown_request;
  assign out_warn_pulse          = res_r.warn_pulse;
  assign out_recover_pulse       = res_r.recover_pulse;
  assign out_status_now          = res_r.status_now;
  assign out_warning_active      = res_r.warning_active;

  `LBM_ASSERT_SAME(a_shutdown_marked, clk, rst_n, $rose(state_r.shutdown_sent), out_valid_r && out_shutdown_request)
  `LBM_ASSERT_NEXT(a_started_sticks, clk, rst_n, state_r.started, state_r.started)
  `LBM_ASSERT_SAME(a_warn_recover_excl, clk, rst_n, out_valid_r, !(out_warn_pulse && out_recover_pulse))
  `LBM_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !out_valid_r, in_ready)

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for low_battery_monitor_unit: a bursty request driver, a stalling
// result monitor and an in-bench supervisor predictor compared field by field.
// Depends on lbm_pkg and the low_battery_monitor_unit RTL.
module tb_top;

  localparam logic [2:0] CODE_UNKNOWN   = 3'd0;
  localparam logic [2:0] CODE_CHARGING  = 3'd4;
  localparam logic [2:0] CODE_UNDEFINED = 3'd7;

  typedef enum logic [1:0] {SINK_OPEN, SINK_EVERY4, SINK_COIN, SINK_TRICKLE} sink_mode_e;

  logic        clk;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_uptime_sec = '0;
  logic        in_sleep_disabled = 1'b0;
  logic [9:0]  in_charge_tenths = '0;
  logic        in_charge_error = 1'b0;
  logic        in_bat_event_valid = 1'b0;
  logic [2:0]  in_bat_state_code = '0;
  logic        in_gauge_alert = 1'b0;
  logic        in_wake_event = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_arm_alert;
  logic [6:0]  out_alert_threshold_pct;
  logic        out_shutdown_request;
  logic        out_warn_pulse;
  logic        out_recover_pulse;
  logic [1:0]  out_status_now;
  logic        out_warning_active;

  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  low_battery_monitor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_uptime_sec(in_uptime_sec), .in_sleep_disabled(in_sleep_disabled),
    .in_charge_tenths(in_charge_tenths), .in_charge_error(in_charge_error),
    .in_bat_event_valid(in_bat_event_valid), .in_bat_state_code(in_bat_state_code),
    .in_gauge_alert(in_gauge_alert), .in_wake_event(in_wake_event),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_arm_alert(out_arm_alert), .out_alert_threshold_pct(out_alert_threshold_pct),
    .out_shutdown_request(out_shutdown_request), .out_warn_pulse(out_warn_pulse),
    .out_recover_pulse(out_recover_pulse), .out_status_now(out_status_now),
    .out_warning_active(out_warning_active),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // limits as programmed
  logic [15:0] lim_start = 16'd20;
  logic [15:0] lim_debounce = 16'd20;
  logic [15:0] lim_awake = 16'd60;
  logic [15:0] lim_sleep = 16'd60;
  logic [6:0]  lim_cutoff = 7'd2;
  logic [6:0]  lim_warn = 7'd8;
  logic [6:0]  lim_hyst = 7'd5;
  logic [6:0]  lim_corr = 7'd1;

  // supervisor state
  logic        sup_started = 1'b0;
  logic        pend_valid = 1'b0;
  logic [31:0] pend_time = '0;
  logic [1:0]  pend_status = lbm_pkg::ST_INIT;
  logic [1:0]  status_cur = lbm_pkg::ST_INIT;
  logic [31:0] eval_time = '0;
  logic        warned = 1'b0;
  logic        alert_latched = 1'b0;
  logic        shutdown_done = 1'b0;

  lbm_pkg::item_t   tick_queue[$];
  lbm_pkg::result_t expected_reports[$];
  int          ticks_queued = 0;
  int          ticks_taken = 0;
  int          mismatch_count = 0;

  logic [31:0] clock_now = '0;
  int unsigned uptime_stride = 18;
  logic        allow_shutdown = 1'b0;

  lbm_pkg::item_t on_port;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] sink_cnt = '0;
  sink_mode_e  sink_mode = SINK_OPEN;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic lbm_pkg::result_t supervise_tick(input lbm_pkg::item_t t);
    lbm_pkg::result_t r;
    logic [1:0]  decoded;
    logic [31:0] age;
    logic [31:0] interval;
    int unsigned cut10, warn10, clear10;
    r = '0;
    cut10 = lim_cutoff * 32'd10;
    warn10 = lim_warn * 32'd10;
    clear10 = (lim_warn + lim_hyst) * 32'd10;
    if (t.bat_state_code <= lbm_pkg::CODE_LAST_CARE) begin
      decoded = lbm_pkg::ST_CARE;
    end else if (t.bat_state_code <= lbm_pkg::CODE_LAST_DONT) begin
      decoded = lbm_pkg::ST_DONT_CARE;
    end else begin
      decoded = lbm_pkg::ST_INIT;
    end
    r.alert_threshold_pct = (lim_cutoff > lim_corr) ? lim_cutoff - lim_corr : 7'd0;
    if (t.wake_event) eval_time = '0;
    if (!sup_started && t.uptime_sec >= {16'd0, lim_start}) begin
      sup_started = 1'b1;
      r.arm_alert = 1'b1;
      if (status_cur == lbm_pkg::ST_INIT) begin
        pend_valid = 1'b1;
        pend_time = t.uptime_sec;
        pend_status = decoded;
      end
    end
    if (sup_started) begin
      if (t.gauge_alert) alert_latched = 1'b1;
      if (t.bat_event_valid) begin
        pend_valid = 1'b1;
        pend_time = t.uptime_sec;
        pend_status = decoded;
      end
    end
    age = t.uptime_sec - pend_time;
    if (pend_valid && age >= {16'd0, lim_debounce}) begin
      status_cur = pend_status;
      pend_valid = 1'b0;
      eval_time = t.uptime_sec;
    end
    interval = t.sleep_disabled ? {16'd0, lim_awake} : {16'd0, lim_sleep};
    age = t.uptime_sec - eval_time;
    if (sup_started && age >= interval) begin
      eval_time = t.uptime_sec;
      if (!t.charge_error) begin
        if (status_cur == lbm_pkg::ST_CARE) begin
          if (alert_latched || t.charge_tenths <= cut10) begin
            if (!shutdown_done) begin
              shutdown_done = 1'b1;
              r.shutdown_request = 1'b1;
            end
          end else if (!warned && t.charge_tenths <= warn10) begin
            warned = 1'b1;
            r.warn_pulse = 1'b1;
          end
        end else if (status_cur == lbm_pkg::ST_DONT_CARE) begin
          if (alert_latched) begin
            if (!shutdown_done) begin
              shutdown_done = 1'b1;
              r.shutdown_request = 1'b1;
            end
          end else if (warned && t.charge_tenths >= clear10) begin
            warned = 1'b0;
            r.recover_pulse = 1'b1;
          end
        end
      end
    end
    r.status_now = status_cur;
    r.warning_active = warned;
    return r;
  endfunction

  task automatic push_tick(input logic [31:0] up, input logic slp, input logic [9:0] chg,
                           input logic err, input logic ev, input logic [2:0] code,
                           input logic alert, input logic wake);
    lbm_pkg::item_t t;
    t.uptime_sec = up;
    t.sleep_disabled = slp;
    t.charge_tenths = chg;
    t.charge_error = err;
    t.bat_event_valid = ev;
    t.bat_state_code = code;
    t.gauge_alert = alert;
    t.wake_event = wake;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // charge clustered around the cutoff, warning and clear levels, or uniform over the full range
  function automatic logic [9:0] pick_charge();
    int unsigned pick, lowest;
    lowest = allow_shutdown ? 0 : lim_cutoff * 32'd10 + 32'd1;
    case ($urandom_range(0, 3))
      0: pick = $urandom_range(0, 1000);
      1: pick = lim_cutoff * 32'd10;
      2: pick = lim_warn * 32'd10;
      default: pick = (lim_warn + lim_hyst) * 32'd10;
    endcase
    pick = pick + $urandom_range(0, 30);
    pick = (pick < 15) ? 0 : pick - 15;
    if (pick < lowest) pick = lowest;
    if (pick > 1000) pick = 1000;
    return pick[9:0];
  endfunction

  task automatic queue_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) begin
        clock_now = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom();
      end else begin
        clock_now = clock_now + $urandom_range(0, uptime_stride);
      end
      push_tick(clock_now, 1'($urandom_range(0, 1)), pick_charge(),
                $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0,
                3'($urandom_range(0, 7)), allow_shutdown && ($urandom_range(0, 39) == 0),
                $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      lbm_pkg::REG_START_DELAY: lim_start = val;
      lbm_pkg::REG_DEBOUNCE:    lim_debounce = val;
      lbm_pkg::REG_AWAKE_INT:   lim_awake = val;
      lbm_pkg::REG_SLEEP_INT:   lim_sleep = val;
      lbm_pkg::REG_CUTOFF:      lim_cutoff = val[6:0];
      lbm_pkg::REG_WARNING:     lim_warn = val[6:0];
      lbm_pkg::REG_WARN_HYST:   lim_hyst = val[6:0];
      default:                  lim_corr = val[6:0];
    endcase
  endtask

  task automatic program_limits(input logic [15:0] sd, db, aw, sl,
                                input logic [6:0] co, wa, hy, ac);
    logic [15:0] slowest;
    write_reg(lbm_pkg::REG_START_DELAY, sd);
    write_reg(lbm_pkg::REG_DEBOUNCE, db);
    write_reg(lbm_pkg::REG_AWAKE_INT, aw);
    write_reg(lbm_pkg::REG_SLEEP_INT, sl);
    write_reg(lbm_pkg::REG_CUTOFF, {9'd0, co});
    write_reg(lbm_pkg::REG_WARNING, {9'd0, wa});
    write_reg(lbm_pkg::REG_WARN_HYST, {9'd0, hy});
    write_reg(lbm_pkg::REG_ALERT_CORR, {9'd0, ac});
    @(posedge clk);
    cfg_we <= 1'b0;
    slowest = (aw > sl) ? aw : sl;
    if (db > slowest) slowest = db;
    uptime_stride = slowest / 4 + 3;
  endtask

  task automatic program_random_limits();
    program_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 40)),
                   16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                   7'($urandom_range(0, 20)), 7'($urandom_range(0, 40)),
                   7'($urandom_range(0, 20)), 7'($urandom_range(0, 25)));
  endtask

  task automatic settle();
    while (ticks_taken != ticks_queued || expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(supervise_tick(on_port));
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          on_port = tick_queue.pop_front();
          in_uptime_sec <= on_port.uptime_sec;
          in_sleep_disabled <= on_port.sleep_disabled;
          in_charge_tenths <= on_port.charge_tenths;
          in_charge_error <= on_port.charge_error;
          in_bat_event_valid <= on_port.bat_event_valid;
          in_bat_state_code <= on_port.bat_state_code;
          in_gauge_alert <= on_port.gauge_alert;
          in_wake_event <= on_port.wake_event;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lbm_pkg::result_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_arm_alert, out_alert_threshold_pct, out_shutdown_request, out_warn_pulse,
               out_recover_pulse, out_status_now, out_warning_active};
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none got %0h", $realtime, got);
        end else begin
          want = expected_reports.pop_front();
          check_field("arm_alert", 8'(want.arm_alert), 8'(got.arm_alert));
          check_field("alert_threshold_pct", 8'(want.alert_threshold_pct),
                      8'(got.alert_threshold_pct));
          check_field("shutdown_request", 8'(want.shutdown_request),
                      8'(got.shutdown_request));
          check_field("warn_pulse", 8'(want.warn_pulse), 8'(got.warn_pulse));
          check_field("recover_pulse", 8'(want.recover_pulse), 8'(got.recover_pulse));
          check_field("status_now", 8'(want.status_now), 8'(got.status_now));
          check_field("warning_active", 8'(want.warning_active), 8'(got.warning_active));
        end
      end
      sink_cnt = sink_cnt + 16'd1;
      if (sink_cnt[5:0] == 6'd0) sink_mode = sink_mode_e'($urandom_range(0, 3));
      case (sink_mode)
        SINK_OPEN:   out_ready <= 1'b1;
        SINK_EVERY4: out_ready <= (sink_cnt[1:0] != 2'd0);
        SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:     out_ready <= (sink_cnt[3:0] == 4'd0);
      endcase
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset limits: start 20, debounce 20, intervals 60, cutoff 2, warning 8, hyst 5
    push_tick(32'd0, 1'b0, 10'd0, 1'b0, 1'b1, CODE_CHARGING, 1'b1, 1'b1);
    push_tick(32'd10, 1'b1, 10'd1000, 1'b1, 1'b1, CODE_UNDEFINED, 1'b0, 1'b0);
    push_tick(32'd19, 1'b0, 10'd500, 1'b0, 1'b0, CODE_UNKNOWN, 1'b1, 1'b0);
    push_tick(32'd20, 1'b0, 10'd500, 1'b0, 1'b0, lbm_pkg::CODE_LAST_CARE, 1'b0, 1'b0);
    push_tick(32'd39, 1'b0, 10'd500, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd40, 1'b1, 10'd500, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd100, 1'b1, 10'd80, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd160, 1'b0, 10'd21, 1'b1, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd220, 1'b0, 10'd21, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd225, 1'b0, 10'd130, 1'b0, 1'b1, lbm_pkg::CODE_LAST_DONT, 1'b0, 1'b0);
    push_tick(32'd245, 1'b1, 10'd129, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd305, 1'b1, 10'd129, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd365, 1'b1, 10'd130, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd366, 1'b1, 10'd80, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b1);
    push_tick(32'd380, 1'b0, 10'd80, 1'b0, 1'b1, CODE_UNDEFINED, 1'b0, 1'b0);
    push_tick(32'd400, 1'b0, 10'd80, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd460, 1'b0, 10'd0, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd470, 1'b0, 10'd500, 1'b0, 1'b1, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd490, 1'b0, 10'd500, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd550, 1'b0, 10'd79, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd551, 1'b0, 10'd500, 1'b0, 1'b1, CODE_CHARGING, 1'b0, 1'b0);
    push_tick(32'hFFFF_FFFF, 1'b1, 10'd1000, 1'b0, 1'b1, lbm_pkg::CODE_LAST_CARE, 1'b0, 1'b0);
    // pending event stamped at uptime zero after wrap
    push_tick(32'd0, 1'b0, 10'd500, 1'b0, 1'b1, lbm_pkg::CODE_LAST_DONT, 1'b0, 1'b0);
    push_tick(32'd20, 1'b0, 10'd500, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    push_tick(32'd80, 1'b0, 10'd130, 1'b0, 1'b0, CODE_UNKNOWN, 1'b0, 1'b0);
    clock_now = 32'd80;
    queue_random(100);
    settle();

    program_limits(16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 7'd0, 7'd0, 7'd0);
    queue_random(120);
    settle();

    program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd30, 7'd100, 7'd100, 7'd100);
    queue_random(100);
    settle();

    program_random_limits();
    clock_now = 32'hFFFF_FF00;
    queue_random(120);
    settle();

    program_random_limits();
    queue_random(120);
    settle();

    program_random_limits();
    queue_random(120);
    settle();

    // shutdown paths from here on: cutoff hits and gauge alerts
    allow_shutdown = 1'b1;
    program_random_limits();
    queue_random(120);
    settle();

    program_limits(16'hFFFF, 16'd7, 16'd3, 16'd11, 7'd100, 7'd100, 7'd100, 7'd0);
    queue_random(100);
    settle();

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lbm_pkg.sv
rtl/core/lbm_cfg_regs.sv
rtl/core/lbm_eval.sv
rtl/core/low_battery_monitor_unit.sv
bench/tb_top.sv
